FILE: hdl/tds_pkg.sv
`timescale 1ns / 1ps

package tds_pkg;

  typedef enum logic [1:0] {
    CONTENT_READING = 2'd0,
    CONTENT_BRIGHT  = 2'd1,
    CONTENT_LOW     = 2'd2,
    CONTENT_CRIT    = 2'd3
  } content_e;

  typedef enum logic [1:0] {
    CFG_CRIT_LIMIT  = 2'd0,
    CFG_BRIGHT_HOLD = 2'd1,
    CFG_LOW_TICKS   = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [7:0] CritLimitReset  = 8'd60;
  localparam logic [7:0] BrightHoldReset = 8'd30;
  localparam logic [8:0] LowTicksReset   = 9'd32;
  localparam logic [7:0] HumidityHi      = 8'd100;

  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEG_H     = 8'h76;
  localparam logic [7:0] SEG_I     = 8'h06;
  localparam logic [7:0] SEG_B     = 8'h7C;
  localparam logic [7:0] SEG_R     = 8'h50;
  localparam logic [7:0] SEG_A     = 8'h77;
  localparam logic [7:0] SEG_T     = 8'h78;
  localparam logic [7:0] SEG_L     = 8'h38;
  localparam logic [7:0] SEG_O     = 8'h5C;
  localparam logic [7:0] SEG_C     = 8'h39;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  // One classified display word passed from the front to the formatter.
  typedef struct packed {
    content_e    content;
    logic [15:0] red;
    logic [7:0]  blue;
    logic        power_down;
    logic        changed;
  } item_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/thermo_display_sequencer.sv
`timescale 1ns / 1ps

// Thermometer display sequencer: one input word per display tick, one output word back.
// s_axis carries the tick inputs in tdata; a word is taken when tvalid and tready are high.
// m_axis carries six segment bytes, the power-down request and the changed flag in tdata,
// and the shown content code in tuser.
// cfg_we_i writes register cfg_idx_i (0 critical tick limit, 1 brightness hold ticks,
// 2 low-battery message ticks) from cfg_wdata_i at a rising edge. The user must write
// only while idle; the block does not enforce it. The front decides the content and
// updates all tick state in the cycle it takes a word, so a new word can be taken
// every cycle while the queue has room. A two-entry queue feeds a two-stage formatter
// (digit extraction, then segment selection into the output register).
// Throughput: one word per cycle while m_axis_tready stays high.
// When the receiver stalls, the output register holds its word, the formatter and queue
// fill, and s_axis_tready drops once both queue entries are in use.
// Reset clears the tick state, the latched reading, the power-down request and all valid
// flags, and loads the registers with 60, 30 and 32.
module thermo_display_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] battery_level, [2] brightness_changed, [17:3] brightness_pct,
  // [18] sample_ready, [34:19] temperature, [42:35] humidity, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] seg_5, [15:8] seg_4, [23:16] seg_3, [31:24] seg_2, [39:32] seg_1,
  // [47:40] seg_0, [48] power_down, [49] shown_changed, [55:50] zero
  output logic [55:0] m_axis_tdata,
  // [1:0] content
  output logic [1:0]  m_axis_tuser
);

  tds_pkg::item_t    front_item, queue_item;
  tds_pkg::content_e content;
  logic              accept, queue_full, queue_valid, queue_pop;
  logic              power_down, shown_changed;
  logic [7:0]        seg_5, seg_4, seg_3, seg_2, seg_1, seg_0;

  assign s_axis_tready = !queue_full;
  assign accept        = s_axis_tvalid && !queue_full;

  tds_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .accept_i             (accept),
    .battery_level_i      (s_axis_tdata[1:0]),
    .brightness_changed_i (s_axis_tdata[2]),
    .brightness_pct_i     (s_axis_tdata[17:3]),
    .sample_ready_i       (s_axis_tdata[18]),
    .temperature_i        (s_axis_tdata[34:19]),
    .humidity_i           (s_axis_tdata[42:35]),
    .item_o               (front_item)
  );

  tds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  tds_format u_format (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (queue_valid),
    .item_i          (queue_item),
    .item_pop_o      (queue_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .seg_5_o         (seg_5),
    .seg_4_o         (seg_4),
    .seg_3_o         (seg_3),
    .seg_2_o         (seg_2),
    .seg_1_o         (seg_1),
    .seg_0_o         (seg_0),
    .content_o       (content),
    .power_down_o    (power_down),
    .shown_changed_o (shown_changed)
  );

  assign m_axis_tdata = {6'd0, shown_changed, power_down,
                         seg_0, seg_1, seg_2, seg_3, seg_4, seg_5};
  assign m_axis_tuser = content;

endmodule

FILE: hdl/tds_front.sv
`timescale 1ns / 1ps

module tds_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tds_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tds_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [1:0]                    battery_level_i,
  input  logic                          brightness_changed_i,
  input  logic [14:0]                   brightness_pct_i,
  input  logic                          sample_ready_i,
  input  logic [15:0]                   temperature_i,
  input  logic [7:0]                    humidity_i,
  output tds_pkg::item_t                item_o
);

  logic [7:0] crit_limit_q, hold_ticks_q;
  logic [8:0] low_ticks_q;

  // The tick counter keeps only its low byte, the only part that is ever looked at.
  logic [7:0] tick_q, tick_d;
  logic [7:0] crit_q, crit_d;
  logic [7:0] hold_q, hold_d;
  logic [15:0] temp_q, temp_d;
  logic [7:0] hum_q, hum_d;
  logic       pd_q, pd_d;
  tds_pkg::content_e shown_content_q;
  logic [15:0] shown_red_q;
  logic [7:0]  shown_blue_q;

  tds_pkg::content_e content;
  logic [15:0] red;
  logic [7:0]  blue;
  logic [7:0]  crit_inc, hold_eff;
  logic        low_hit, changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_limit_q <= tds_pkg::CritLimitReset;
      hold_ticks_q <= tds_pkg::BrightHoldReset;
      low_ticks_q  <= tds_pkg::LowTicksReset;
    end else if (cfg_we_i) begin
      unique case (tds_pkg::cfg_reg_e'(cfg_idx_i))
        tds_pkg::CFG_CRIT_LIMIT:  crit_limit_q <= cfg_wdata_i[7:0];
        tds_pkg::CFG_BRIGHT_HOLD: hold_ticks_q <= cfg_wdata_i[7:0];
        tds_pkg::CFG_LOW_TICKS:   low_ticks_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_d   = tick_q + 8'd1;
    crit_d   = crit_q;
    hold_d   = hold_q;
    temp_d   = temp_q;
    hum_d    = hum_q;
    pd_d     = pd_q;
    content  = tds_pkg::CONTENT_READING;
    red      = 16'd0;
    blue     = 8'd0;
    crit_inc = (crit_q == 8'hFF) ? crit_q : crit_q + 8'd1;
    hold_eff = brightness_changed_i ? hold_ticks_q : hold_q;
    low_hit  = ({1'b0, tick_d} < low_ticks_q);

    priority if (battery_level_i == 2'd2) begin
      crit_d  = crit_inc;
      content = tds_pkg::CONTENT_CRIT;
      if (crit_inc >= crit_limit_q) begin
        pd_d = 1'b1;
      end
    end else if (battery_level_i == 2'd1 && low_hit) begin
      crit_d  = 8'd0;
      content = tds_pkg::CONTENT_LOW;
    end else if (hold_eff != 8'd0) begin
      crit_d  = 8'd0;
      hold_d  = hold_eff - 8'd1;
      content = tds_pkg::CONTENT_BRIGHT;
      red     = {1'b0, brightness_pct_i};
    end else begin
      crit_d = 8'd0;
      hold_d = hold_eff;
      if (sample_ready_i) begin
        temp_d = temperature_i;
        hum_d  = humidity_i;
      end
      red  = temp_d;
      blue = hum_d;
    end

    priority if (content != shown_content_q) begin
      changed = 1'b1;
    end else if (content == tds_pkg::CONTENT_READING) begin
      changed = (red != shown_red_q) || (blue != shown_blue_q);
    end else if (content == tds_pkg::CONTENT_BRIGHT) begin
      changed = (red != shown_red_q);
    end else begin
      changed = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q          <= 8'd0;
      crit_q          <= 8'd0;
      hold_q          <= 8'd0;
      temp_q          <= 16'd0;
      hum_q           <= 8'd0;
      pd_q            <= 1'b0;
      shown_content_q <= tds_pkg::CONTENT_READING;
      shown_red_q     <= 16'd0;
      shown_blue_q    <= 8'd0;
    end else if (accept_i) begin
      tick_q          <= tick_d;
      crit_q          <= crit_d;
      hold_q          <= hold_d;
      temp_q          <= temp_d;
      hum_q           <= hum_d;
      pd_q            <= pd_d;
      shown_content_q <= content;
      shown_red_q     <= red;
      shown_blue_q    <= blue;
    end
  end

  assign item_o.content    = content;
  assign item_o.red        = red;
  assign item_o.blue       = blue;
  assign item_o.power_down = pd_d;
  assign item_o.changed    = changed;

endmodule

FILE: hdl/tds_queue.sv
`timescale 1ns / 1ps

module tds_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tds_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tds_pkg::item_t item_o
);

  tds_pkg::item_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hdl/tds_format.sv
`timescale 1ns / 1ps

module tds_format (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  tds_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     seg_5_o,
  output logic [7:0]     seg_4_o,
  output logic [7:0]     seg_3_o,
  output logic [7:0]     seg_2_o,
  output logic [7:0]     seg_1_o,
  output logic [7:0]     seg_0_o,
  output tds_pkg::content_e content_o,
  output logic           power_down_o,
  output logic           shown_changed_o
);

  // Digit stage
  typedef struct packed {
    tds_pkg::content_e content;
    logic       power_down;
    logic       changed;
    logic       neg;
    logic [1:0] d4;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
    logic       blue_hi;
    logic [3:0] blue_tens;
    logic [3:0] blue_ones;
  } digits_t;

  digits_t    dig_d, dig_q;
  logic       dig_valid_q, out_valid_q;
  logic       adv_out, adv_dig;

  logic [15:0] mag;
  logic [7:0]  ip, fp;
  logic [6:0]  rem;
  logic [14:0] rem_mul;
  logic [11:0] frac10;
  logic [14:0] frac100;
  logic [6:0]  hund;
  logic [15:0] blue_mul;

  assign adv_out    = !out_valid_q || out_ready_i;
  assign adv_dig    = !dig_valid_q || adv_out;
  assign item_pop_o = adv_dig && item_valid_i;

  always_comb begin
    mag = item_i.red[15] ? (~item_i.red + 16'd1) : item_i.red;
    ip  = mag[15:8];
    fp  = mag[7:0];
    priority if (ip >= 8'd200) begin
      dig_d.d4 = 2'd2;
      rem      = 7'(ip - 8'd200);
    end else if (ip >= 8'd100) begin
      dig_d.d4 = 2'd1;
      rem      = 7'(ip - 8'd100);
    end else begin
      dig_d.d4 = 2'd0;
      rem      = ip[6:0];
    end
    // Divide by ten through a reciprocal; exact for values below 180.
    rem_mul  = 15'(rem) * 15'd205;
    dig_d.d3 = rem_mul[14:11];
    dig_d.d2 = 4'(rem - 7'(dig_d.d3) * 7'd10);
    frac10   = 12'(fp) * 12'd10;
    frac100  = 15'(fp) * 15'd100;
    dig_d.d1 = frac10[11:8];
    hund     = frac100[14:8];
    dig_d.d0 = 4'(hund - 7'(dig_d.d1) * 7'd10);

    blue_mul        = 16'(item_i.blue) * 16'd205;
    dig_d.blue_hi   = (item_i.blue >= tds_pkg::HumidityHi);
    dig_d.blue_tens = blue_mul[14:11];
    dig_d.blue_ones = 4'(item_i.blue - 8'(dig_d.blue_tens) * 8'd10);

    dig_d.content    = item_i.content;
    dig_d.power_down = item_i.power_down;
    dig_d.changed    = item_i.changed;
    dig_d.neg        = item_i.red[15];
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      dig_q <= dig_d;
    end
  end

  // Segment stage
  logic [7:0] r0, r1, r2, r3, b1, b0;
  logic [7:0] s4, s3, s2, s1, s0;
  logic       small_int, mid_int;

  always_comb begin
    s4 = tds_pkg::digit_seg({2'b00, dig_q.d4});
    s3 = tds_pkg::digit_seg(dig_q.d3);
    s2 = tds_pkg::digit_seg(dig_q.d2);
    s1 = tds_pkg::digit_seg(dig_q.d1);
    s0 = tds_pkg::digit_seg(dig_q.d0);
    small_int = (dig_q.d4 == 2'd0) && (dig_q.d3 == 4'd0);
    mid_int   = (dig_q.d4 == 2'd0);

    // Negative values give up the leftmost digit to the minus sign.
    priority if (small_int) begin
      r0 = dig_q.neg ? tds_pkg::SEG_MINUS : tds_pkg::SEG_BLANK;
      r1 = s2 | tds_pkg::SEG_DP;
      r2 = s1;
      r3 = s0;
    end else if (mid_int) begin
      if (dig_q.neg) begin
        r0 = tds_pkg::SEG_MINUS;
        r1 = s3;
        r2 = s2 | tds_pkg::SEG_DP;
        r3 = s1;
      end else begin
        r0 = s3;
        r1 = s2 | tds_pkg::SEG_DP;
        r2 = s1;
        r3 = s0;
      end
    end else begin
      if (dig_q.neg) begin
        r0 = tds_pkg::SEG_MINUS;
        r1 = s4;
        r2 = s3;
        r3 = s2 | tds_pkg::SEG_DP;
      end else begin
        r0 = s4;
        r1 = s3;
        r2 = s2 | tds_pkg::SEG_DP;
        r3 = s1;
      end
    end

    unique case (dig_q.content)
      tds_pkg::CONTENT_CRIT: begin
        r0 = tds_pkg::SEG_B;
        r1 = tds_pkg::SEG_A;
        r2 = tds_pkg::SEG_T;
        r3 = tds_pkg::SEG_T;
        b1 = tds_pkg::SEG_C;
        b0 = tds_pkg::SEG_R;
      end
      tds_pkg::CONTENT_LOW: begin
        r0 = tds_pkg::SEG_B;
        r1 = tds_pkg::SEG_A;
        r2 = tds_pkg::SEG_T;
        r3 = tds_pkg::SEG_T;
        b1 = tds_pkg::SEG_L;
        b0 = tds_pkg::SEG_O;
      end
      tds_pkg::CONTENT_BRIGHT: begin
        b1 = tds_pkg::SEG_B;
        b0 = tds_pkg::SEG_R;
      end
      default: begin
        b1 = dig_q.blue_hi ? tds_pkg::SEG_H : tds_pkg::digit_seg(dig_q.blue_tens);
        b0 = dig_q.blue_hi ? tds_pkg::SEG_I : tds_pkg::digit_seg(dig_q.blue_ones);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && dig_valid_q) begin
      seg_5_o         <= r0;
      seg_4_o         <= r1;
      seg_3_o         <= r2;
      seg_2_o         <= r3;
      seg_1_o         <= b1;
      seg_0_o         <= b0;
      content_o       <= dig_q.content;
      power_down_o    <= dig_q.power_down;
      shown_changed_o <= dig_q.changed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_dig) begin
        dig_valid_q <= item_valid_i;
      end
      if (adv_out) begin
        out_valid_q <= dig_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/tds_checker.sv
`timescale 1ns / 1ps

module tds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic out_acc;
  logic pd_seen_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_seen_q <= 1'b0;
    end else if (out_acc && m_axis_tdata[48]) begin
      pd_seen_q <= 1'b1;
    end
  end

  // A stalled output word must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // The power-down request stays set once any word has carried it.
  a_pd_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && pd_seen_q |-> m_axis_tdata[48])
    else $error("power-down request dropped");

  // Battery messages spell bAtt on the red digits.
  a_batt_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tds_pkg::CONTENT_CRIT
      || m_axis_tuser == tds_pkg::CONTENT_LOW) |->
      m_axis_tdata[7:0] == tds_pkg::SEG_B && m_axis_tdata[15:8] == tds_pkg::SEG_A
      && m_axis_tdata[23:16] == tds_pkg::SEG_T && m_axis_tdata[31:24] == tds_pkg::SEG_T)
    else $error("battery message segments wrong");

  // Brightness shows br on the blue digits.
  a_bright_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tds_pkg::CONTENT_BRIGHT |->
      m_axis_tdata[39:32] == tds_pkg::SEG_B && m_axis_tdata[47:40] == tds_pkg::SEG_R)
    else $error("brightness label segments wrong");

endmodule

bind thermo_display_sequencer tds_checker u_tds_checker (.*);

FILE: tb/tds_display_checker.sv
`timescale 1ns / 1ps

package tds_tb_pkg;

  typedef enum logic [1:0] {
    BAT_NORMAL   = 2'd0,
    BAT_LOW      = 2'd1,
    BAT_DEPLETED = 2'd2,
    BAT_SPARE    = 2'd3
  } battery_e;

  // Members run from the top bit down, so {5'b0, tick_t} matches the s_axis_tdata layout.
  typedef struct packed {
    logic [7:0]  humidity;
    logic [15:0] temperature;
    logic        sample_ready;
    logic [14:0] brightness_pct;
    logic        brightness_changed;
    battery_e    battery_level;
  } tick_t;

endpackage

module tds_display_checker
  import tds_pkg::*;
  import tds_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [47:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [55:0] m_data_i,
  input  logic [1:0]  m_user_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned words_o,
  output int unsigned changes_o,
  output logic [3:0]  kinds_seen_o,
  output logic        pd_seen_o
);

  // Byte i of segs is byte i of m_axis_tdata: seg_5 first, seg_0 last.
  typedef struct packed {
    content_e        content;
    logic            power_down;
    logic            changed;
    logic [5:0][7:0] segs;
  } display_t;

  localparam logic [9:0][7:0] DigitSegs = {
    8'h67, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  logic [7:0]  crit_limit, hold_ticks;
  logic [8:0]  low_ticks;
  logic [15:0] tick_ctr, temp_latch, shown_red;
  logic [7:0]  crit_run, hold_left, hum_latch, shown_blue;
  content_e    shown_kind;
  logic        pd_latch;

  display_t expected_displays[$];

  // Signed 8.8 onto the four red digits, leftmost digit in byte 0.
  function automatic logic [3:0][7:0] format_fixed(logic [15:0] raw);
    logic [3:0][7:0] s;
    logic            neg;
    logic [15:0]     mag;
    int unsigned     ip, fp, d4, d3, d2, d1, d0;
    neg = raw[15];
    mag = neg ? (~raw + 16'd1) : raw;
    ip  = mag[15:8];
    fp  = mag[7:0];
    d4  = ip / 100;
    d3  = (ip / 10) % 10;
    d2  = ip % 10;
    d1  = (fp * 10) >> 8;
    d0  = ((fp * 100) >> 8) - d1 * 10;
    if (neg) begin
      s[0] = SEG_MINUS;
      if (d4 == 0 && d3 == 0) begin
        s[1] = DigitSegs[d2] | SEG_DP;
        s[2] = DigitSegs[d1];
        s[3] = DigitSegs[d0];
      end else if (d4 == 0) begin
        s[1] = DigitSegs[d3];
        s[2] = DigitSegs[d2] | SEG_DP;
        s[3] = DigitSegs[d1];
      end else begin
        s[1] = DigitSegs[d4];
        s[2] = DigitSegs[d3];
        s[3] = DigitSegs[d2] | SEG_DP;
      end
    end else if (d4 == 0 && d3 == 0) begin
      s[0] = SEG_BLANK;
      s[1] = DigitSegs[d2] | SEG_DP;
      s[2] = DigitSegs[d1];
      s[3] = DigitSegs[d0];
    end else if (d4 == 0) begin
      s[0] = DigitSegs[d3];
      s[1] = DigitSegs[d2] | SEG_DP;
      s[2] = DigitSegs[d1];
      s[3] = DigitSegs[d0];
    end else begin
      s[0] = DigitSegs[d4];
      s[1] = DigitSegs[d3];
      s[2] = DigitSegs[d2] | SEG_DP;
      s[3] = DigitSegs[d1];
    end
    return s;
  endfunction

  function automatic display_t advance_tick(tick_t t);
    display_t    d;
    logic [15:0] red;
    logic [7:0]  blue;
    logic        decided;
    red        = '0;
    blue       = '0;
    decided    = 1'b0;
    d.content  = CONTENT_READING;
    tick_ctr   = tick_ctr + 16'd1;

    if (t.battery_level == BAT_DEPLETED) begin
      if (crit_run != 8'hFF) crit_run = crit_run + 8'd1;
      if (crit_run >= crit_limit) pd_latch = 1'b1;
      d.content = CONTENT_CRIT;
      decided   = 1'b1;
    end else begin
      crit_run = '0;
      if (t.battery_level == BAT_LOW && {1'b0, tick_ctr[7:0]} < low_ticks) begin
        d.content = CONTENT_LOW;
        decided   = 1'b1;
      end
    end

    if (!decided) begin
      if (t.brightness_changed) hold_left = hold_ticks;
      if (hold_left != 0) begin
        d.content = CONTENT_BRIGHT;
        red       = {1'b0, t.brightness_pct};
        hold_left = hold_left - 8'd1;
      end else begin
        if (t.sample_ready) begin
          temp_latch = t.temperature;
          hum_latch  = t.humidity;
        end
        red  = temp_latch;
        blue = hum_latch;
      end
    end

    case (d.content)
      CONTENT_CRIT, CONTENT_LOW: begin
        d.segs[0] = SEG_B;
        d.segs[1] = SEG_A;
        d.segs[2] = SEG_T;
        d.segs[3] = SEG_T;
        d.segs[4] = (d.content == CONTENT_CRIT) ? SEG_C : SEG_L;
        d.segs[5] = (d.content == CONTENT_CRIT) ? SEG_R : SEG_O;
      end
      CONTENT_BRIGHT: begin
        d.segs[3:0] = format_fixed(red);
        d.segs[4]   = SEG_B;
        d.segs[5]   = SEG_R;
      end
      default: begin
        d.segs[3:0] = format_fixed(red);
        if (blue >= HumidityHi) begin
          d.segs[4] = SEG_H;
          d.segs[5] = SEG_I;
        end else begin
          d.segs[4] = DigitSegs[blue / 8'd10];
          d.segs[5] = DigitSegs[blue % 8'd10];
        end
      end
    endcase

    // Messages compare the kind only; brightness adds the red value, readings both values.
    if (d.content != shown_kind) d.changed = 1'b1;
    else if (d.content == CONTENT_READING) d.changed = (red != shown_red) || (blue != shown_blue);
    else if (d.content == CONTENT_BRIGHT) d.changed = (red != shown_red);
    else d.changed = 1'b0;

    shown_kind   = d.content;
    shown_red    = red;
    shown_blue   = blue;
    d.power_down = pd_latch;
    return d;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
    $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    display_t want;
    if (!rst_ni) begin
      crit_limit   = CritLimitReset;
      hold_ticks   = BrightHoldReset;
      low_ticks    = LowTicksReset;
      tick_ctr     = '0;
      crit_run     = '0;
      hold_left    = '0;
      temp_latch   = '0;
      hum_latch    = '0;
      shown_kind   = CONTENT_READING;
      shown_red    = '0;
      shown_blue   = '0;
      pd_latch     = 1'b0;
      expected_displays.delete();
      errors_o     = 0;
      pending_o    = 0;
      words_o      = 0;
      changes_o    = 0;
      kinds_seen_o = '0;
      pd_seen_o    = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CRIT_LIMIT:  crit_limit = cfg_wdata_i[7:0];
          CFG_BRIGHT_HOLD: hold_ticks = cfg_wdata_i[7:0];
          CFG_LOW_TICKS:   low_ticks  = cfg_wdata_i;
          default: ;
        endcase
      end

      if (s_valid_i && s_ready_i)
        expected_displays.push_back(advance_tick(tick_t'(s_data_i[42:0])));

      if (m_valid_i && m_ready_i) begin
        words_o++;
        kinds_seen_o[m_user_i] = 1'b1;
        if (m_data_i[48]) pd_seen_o = 1'b1;
        if (m_data_i[49]) changes_o++;
        if (expected_displays.size() == 0) begin
          $display("%0t ns: display word 0x%0h arrived with no tick waiting for it",
                   $time, m_data_i);
          errors_o++;
        end else begin
          want = expected_displays.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (m_data_i[8*i +: 8] !== want.segs[i])
              report_mismatch($sformatf("seg_%0d", 5 - i), want.segs[i], m_data_i[8*i +: 8]);
          end
          if (m_user_i !== want.content) report_mismatch("content", want.content, m_user_i);
          if (m_data_i[48] !== want.power_down)
            report_mismatch("power_down", want.power_down, m_data_i[48]);
          if (m_data_i[49] !== want.changed)
            report_mismatch("shown_changed", want.changed, m_data_i[49]);
        end
      end
      pending_o = expected_displays.size();
    end
  end

endmodule

FILE: tb/thermo_display_sequencer_tb.sv
`timescale 1ns / 1ps

module thermo_display_sequencer_tb;
  import tds_pkg::*;
  import tds_tb_pkg::*;

  localparam int unsigned LongStall  = 200;
  localparam int unsigned DrainLimit = 5000;
  localparam int unsigned EndCycles  = 10;

  typedef enum int unsigned {
    SCN_READING,
    SCN_BRIGHT,
    SCN_CRIT,
    SCN_LOW,
    SCN_NOISE
  } scenario_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned fail_count, pending, words, changes;
  int unsigned drain_fail = 0;
  logic [3:0]  kinds;
  logic        pd_seen;

  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  bit rx_stall_req = 1'b0;

  thermo_display_sequencer u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  tds_display_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .errors_o     (fail_count),
    .pending_o    (pending),
    .words_o      (words),
    .changes_o    (changes),
    .kinds_seen_o (kinds),
    .pd_seen_o    (pd_seen)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #400_000;
    $display("%0t ns: run did not finish in time, %0d words still expected", $time, pending);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random hold-offs per word, plus one long stall on request.
  initial begin : display_sink
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
        rx_stall_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  function automatic tick_t tick_of(battery_e bat, bit chg, logic [14:0] pct, bit rdy,
                                    logic [15:0] temp, logic [7:0] hum);
    tick_t t;
    t.battery_level      = bat;
    t.brightness_changed = chg;
    t.brightness_pct     = pct;
    t.sample_ready       = rdy;
    t.temperature        = temp;
    t.humidity           = hum;
    return t;
  endfunction

  function automatic tick_t noise_tick();
    return tick_of(battery_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 15'($urandom),
                   1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
  endfunction

  task automatic send_tick(tick_t t);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, t};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Stop offering words; wait until all expected display words are taken or give up.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DrainLimit);
    if (pending != 0) begin
      $display("%0t ns: %0d expected display words never arrived", $time, pending);
      drain_fail++;
    end
  endtask

  task automatic configure(logic [7:0] crit, logic [7:0] hold, logic [8:0] low);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CRIT_LIMIT;
    cfg_wdata_i <= {1'b0, crit};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BRIGHT_HOLD;
    cfg_wdata_i <= {1'b0, hold};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LOW_TICKS;
    cfg_wdata_i <= low;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Bursts of one situation at a time, so critical streaks, brightness holds and
  // steady readings all last long enough to matter.
  task automatic random_ticks(int unsigned n);
    tick_t       t;
    scenario_e   kind;
    int unsigned w, run;
    logic [14:0] pct;
    while (n != 0) begin
      w    = $urandom_range(0, 9);
      kind = (w < 3) ? SCN_READING : (w < 5) ? SCN_BRIGHT : (w < 7) ? SCN_CRIT :
             (w < 8) ? SCN_LOW : SCN_NOISE;
      run  = $urandom_range(1, 12);
      pct  = 15'($urandom);
      for (int unsigned k = 0; k < run && n != 0; k++) begin
        t = noise_tick();
        case (kind)
          SCN_READING: begin
            t.battery_level      = ($urandom_range(0, 3) == 0) ? BAT_SPARE : BAT_NORMAL;
            t.brightness_changed = 1'b0;
            t.sample_ready       = ($urandom_range(0, 2) == 0);
          end
          SCN_BRIGHT: begin
            t.battery_level      = BAT_NORMAL;
            t.brightness_changed = (k == 0);
            if ($urandom_range(0, 3) != 0) t.brightness_pct = pct;
          end
          SCN_CRIT: t.battery_level = BAT_DEPLETED;
          SCN_LOW:  t.battery_level = BAT_LOW;
          default: ;
        endcase
        send_tick(t);
        n--;
      end
    end
  endtask

  initial begin : stimulus
    wait (rst_ni);
    @(posedge clk_i);

    // Reset settings: number formats, humidity limits, then each message and the hold.
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 1, 16'h0000, 8'd0));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 1, 16'h7FFF, 8'd99));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 1, 16'h8000, 8'd100));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 1, 16'h8001, 8'd255));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 1, 16'hFE80, 8'd5));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 1, 16'hF3C0, 8'd0));
    send_tick(tick_of(BAT_NORMAL, 0, 15'h7FFF, 1, 16'h1980, 8'd45));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 1, 16'h6400, 8'd60));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 0, 16'h1234, 8'd77));
    send_tick(tick_of(BAT_SPARE, 0, 15'd0, 1, 16'h0100, 8'd50));
    send_tick(tick_of(BAT_NORMAL, 1, 15'h7FFF, 1, 16'h0A00, 8'd10));
    send_tick(tick_of(BAT_NORMAL, 0, 15'h7FFF, 1, 16'h0A00, 8'd10));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd25600, 0, 16'h0000, 8'd0));
    send_tick(tick_of(BAT_NORMAL, 0, 15'd0, 0, 16'h0000, 8'd0));
    send_tick(tick_of(BAT_LOW, 1, 15'h4000, 1, 16'hFFFF, 8'd200));
    send_tick(tick_of(BAT_LOW, 0, 15'h4000, 1, 16'hFFFF, 8'd200));
    send_tick(tick_of(BAT_DEPLETED, 1, 15'h1234, 1, 16'h5555, 8'd33));
    send_tick(tick_of(BAT_DEPLETED, 0, 15'h1234, 1, 16'h5555, 8'd33));
    send_tick(tick_of(BAT_LOW, 0, 15'h1234, 0, 16'h5555, 8'd33));
    send_tick(tick_of(BAT_NORMAL, 0, 15'h0080, 1, 16'h2000, 8'd30));
    send_tick(tick_of(BAT_DEPLETED, 0, 15'h0080, 1, 16'h2000, 8'd30));
    send_tick(tick_of(BAT_NORMAL, 0, 15'h0080, 0, 16'h2000, 8'd30));
    random_ticks(40);
    drain();

    // No brightness, no low message, a limit the critical bursts never reach.
    configure(8'd200, 8'd0, 9'd0);
    random_ticks(60);
    drain();

    // Top limit and hold, low ticks 256, and a long receiver stall while words arrive.
    configure(8'd255, 8'd255, 9'd256);
    rx_stall_req = 1'b1;
    tx_idle      = 1'b0;
    random_ticks(40);
    tx_idle      = 1'b1;
    random_ticks(40);
    drain();

    // A short limit so a critical burst raises power-down.
    configure(8'd4, 8'd3, 9'd100);
    random_ticks(70);
    drain();

    configure(8'd0, 8'd1, 9'd511);
    rx_idle = 1'b0;
    random_ticks(60);
    drain();
    rx_idle = 1'b1;

    configure(8'd1, 8'd8, 9'd200);
    rx_stall_req = 1'b1;
    random_ticks(100);
    drain();

    repeat (EndCycles) @(posedge clk_i);
    $display("Checked %0d display words over six register settings, %0d flagged as changed.",
             words, changes);
    $display("Content kinds seen (critical, low, brightness, reading): %b; power-down: %0d.",
             kinds, pd_seen);
    if (fail_count == 0 && drain_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
